/* hw/rtl/gec_pkg.sv */
// ----------------------------------------------------------------------------
// gec_pkg
// Shared types, constants and the type GUID table of the GPT entry decoder.
// ----------------------------------------------------------------------------
package gec_pkg;

   localparam int MAX_ENTRIES     = 1024;
   localparam int POS_W           = $clog2(MAX_ENTRIES + 1);
   localparam int OFF_W           = POS_W + 32;
   localparam int IDX_W           = 10;
   localparam int SS_W            = 17;
   localparam int CODE_W          = 4;
   localparam int KNOWN_TYPES     = 9;
   localparam int FIFO_DEPTH      = 4;
   localparam int FIFO_PTR_W      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int SETTLE_CYCLES   = 3;
   localparam int SETTLE_W        = $clog2(SETTLE_CYCLES + 1);

   localparam logic [31:0]       MIN_ENTRY_BYTES = 32'd128;
   localparam logic [CODE_W-1:0] TYPE_UNKNOWN    = 4'd9;

   // configuration register indexes
   localparam logic [2:0] REG_SECTOR_SIZE     = 3'd0;
   localparam logic [2:0] REG_ARRAY_START_LBA = 3'd1;
   localparam logic [2:0] REG_ENTRY_COUNT     = 3'd2;
   localparam logic [2:0] REG_ENTRY_BYTES     = 3'd3;
   localparam logic [2:0] REG_STORAGE_BYTES   = 3'd4;

   localparam logic [63:0] TYPE_LO [KNOWN_TYPES] = '{
      64'h11D2F81FC12A7328, 64'h4433B9E5EBD0A0A2, 64'h4DB80B5CE3C9E316,
      64'h4D4006D1DE94BBA4, 64'h477284830FC63DAF, 64'h43C4A4AB0657FD6D,
      64'h44C2F507E6D6D379, 64'h11AA000048465300, 64'h11AA00007C3457EF
   };
   localparam logic [63:0] TYPE_HI [KNOWN_TYPES] = '{
      64'h3BC93EC9A0004BBA, 64'hC79926B7B668C087, 64'hAE1502F02DF97D81,
      64'hACD67901D5BF6AA1, 64'hE47D47D8693D798E, 64'h4F4F4BC83309E584,
      64'h28F93D2A8F233CA2, 64'hACEC4365300011AA, 64'hACEC4365300011AA
   };

   // settings seen by the front and back parts
   typedef struct packed {
      logic [SS_W-1:0]  sector_size;
      logic [31:0]      entry_bytes;
      logic [63:0]      storage_bytes;
      logic [63:0]      base_end;     // array_start_lba * sector_size + entry_bytes
      logic [POS_W-1:0] cap;          // entry count limited to MAX_ENTRIES
      logic             disabled;
      logic             settling;
      logic             reload;       // last settle cycle: rebuild running offset
   } cfg_type;

   // one classified entry, front to back
   typedef struct packed {
      logic             emit;
      logic             stopped;
      logic [IDX_W-1:0] index;
      logic [63:0]      guid_lo;
      logic [63:0]      guid_hi;
      logic [63:0]      first;
      logic [63:0]      last;
      logic [63:0]      attr;
   } job_type;

   function automatic logic [CODE_W-1:0] classify(input logic [63:0] lo,
                                                  input logic [63:0] hi);
      logic [CODE_W-1:0] code;
      code = TYPE_UNKNOWN;
      for (int k = KNOWN_TYPES - 1; k >= 0; k--) begin
         if (TYPE_LO[k] == lo && TYPE_HI[k] == hi) begin
            code = CODE_W'(k);
         end
      end
      return code;
   endfunction

endpackage

/* hw/rtl/gec_csr.sv */
// ----------------------------------------------------------------------------
// gec_csr
// Header registers, derived limits and the array base product.
// ----------------------------------------------------------------------------
module gec_csr
   import gec_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data,
   output cfg_type     cfg
);

   logic [SS_W-1:0]     sector_size_ff;
   logic [63:0]         array_start_ff;
   logic [31:0]         entry_count_ff;
   logic [31:0]         entry_bytes_ff;
   logic [63:0]         storage_bytes_ff;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   logic [SS_W+31:0]    prod_lo_ff, prod_lo_in;
   logic [31:0]         prod_hi_ff, prod_hi_in;
   logic [63:0]         base_ff, base_in;
   logic [63:0]         base_end_ff, base_end_in;

   logic                wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_size_ff   <= SS_W'(512);
         array_start_ff   <= 64'd2;
         entry_count_ff   <= 32'd128;
         entry_bytes_ff   <= 32'd128;
         storage_bytes_ff <= 64'd0;
      end else if (wr) begin
         case (csr_index)
            REG_SECTOR_SIZE:     sector_size_ff   <= csr_data[SS_W-1:0];
            REG_ARRAY_START_LBA: array_start_ff   <= csr_data;
            REG_ENTRY_COUNT:     entry_count_ff   <= csr_data[31:0];
            REG_ENTRY_BYTES:     entry_bytes_ff   <= csr_data[31:0];
            REG_STORAGE_BYTES:   storage_bytes_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // base product split in two halves, registered, then summed
   always_comb begin
      prod_lo_in  = (SS_W+32)'(array_start_ff[31:0]) * (SS_W+32)'(sector_size_ff);
      prod_hi_in  = 32'(array_start_ff[63:32]) * 32'(sector_size_ff);
      base_in     = 64'(prod_lo_ff) + {prod_hi_ff, 32'd0};
      base_end_in = base_ff + 64'(entry_bytes_ff);
      settle_in   = settle_ff;
      if (wr) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_lo_ff  <= prod_lo_in;
      prod_hi_ff  <= prod_hi_in;
      base_ff     <= base_in;
      base_end_ff <= base_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         settle_ff <= settle_in;
      end
   end

   always_comb begin
      cfg.sector_size   = sector_size_ff;
      cfg.entry_bytes   = entry_bytes_ff;
      cfg.storage_bytes = storage_bytes_ff;
      cfg.base_end      = base_end_ff;
      cfg.cap           = (entry_count_ff > 32'(MAX_ENTRIES)) ? POS_W'(MAX_ENTRIES)
                                                              : entry_count_ff[POS_W-1:0];
      cfg.disabled      = (sector_size_ff == '0) || (entry_bytes_ff < MIN_ENTRY_BYTES) ||
                          (entry_count_ff == '0);
      cfg.settling      = (settle_ff != '0);
      cfg.reload        = (settle_ff == SETTLE_W'(1));
   end

endmodule

/* hw/rtl/gec_front.sv */
// ----------------------------------------------------------------------------
// gec_front
// Accepts entries, tracks table position and decides keep, skip or stop.
// ----------------------------------------------------------------------------
module gec_front
   import gec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         new_table,
   input  logic [63:0]  guid_lo,
   input  logic [63:0]  guid_hi,
   input  logic [63:0]  first_lba,
   input  logic [63:0]  last_lba,
   input  logic [63:0]  attr_bits,
   input  logic         queue_full,
   output logic         push,
   output job_type      job
);

   logic [POS_W-1:0] pos_ff, pos_in, pos_cur;
   logic [IDX_W-1:0] cnt_ff, cnt_in, cnt_cur;
   logic             halt_ff, halt_in, halt_cur;
   logic [OFF_W-1:0] off_ff, off_in, off_cur;   // pos * entry_bytes
   logic [OFF_W-1:0] pe_ff, pe_in;
   logic [63:0]      end_addr;

   assign req_tready = !queue_full && !cfg.settling;
   assign push       = req_tvalid && req_tready;
   assign pe_in      = OFF_W'(pos_ff) * OFF_W'(cfg.entry_bytes);

   always_comb begin
      pos_cur  = new_table ? '0 : pos_ff;
      cnt_cur  = new_table ? '0 : cnt_ff;
      halt_cur = new_table ? 1'b0 : halt_ff;
      off_cur  = new_table ? '0 : off_ff;
      end_addr = cfg.base_end + 64'(off_cur);

      pos_in  = pos_cur;
      cnt_in  = cnt_cur;
      halt_in = halt_cur;
      off_in  = off_cur;

      job.emit    = 1'b0;
      job.stopped = 1'b0;
      job.index   = cnt_cur;
      job.guid_lo = guid_lo;
      job.guid_hi = guid_hi;
      job.first   = first_lba;
      job.last    = last_lba;
      job.attr    = attr_bits;

      if (cfg.disabled) begin
         // nothing beyond the new table clear
      end else if (halt_cur) begin
         job.stopped = 1'b1;
      end else if (pos_cur >= cfg.cap || end_addr > cfg.storage_bytes) begin
         halt_in     = 1'b1;
         job.stopped = 1'b1;
      end else begin
         pos_in = pos_cur + 1'b1;
         off_in = off_cur + OFF_W'(cfg.entry_bytes);
         if (!((guid_lo == '0 && guid_hi == '0) || first_lba > last_lba)) begin
            job.emit = 1'b1;
            cnt_in   = cnt_cur + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pe_ff <= pe_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         cnt_ff  <= '0;
         halt_ff <= 1'b0;
         off_ff  <= '0;
      end else if (push) begin
         pos_ff  <= pos_in;
         cnt_ff  <= cnt_in;
         halt_ff <= halt_in;
         off_ff  <= off_in;
      end else if (cfg.reload) begin
         // entry size may have changed: rebuild the running offset
         off_ff <= pe_ff;
      end
   end

`ifndef SYNTHESIS
   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      halt_ff && !(push && new_table) |=> halt_ff)
      else $error("halt cleared without a new table");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && job.emit |=> cnt_ff == $past(job.index) + 1'b1)
      else $error("record index did not advance");

   a_no_accept_settling: assert property (@(posedge clock) disable iff (reset)
      cfg.settling |-> !push)
      else $error("item taken while settings settle");
`endif

endmodule

/* hw/rtl/gec_fifo.sv */
// ----------------------------------------------------------------------------
// gec_fifo
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module gec_fifo
   import gec_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_data
);

   job_type               mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, rd_ff;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> count_ff == FIFO_CNT_W'(FIFO_DEPTH))
      else $error("queue count moved past depth");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue popped while empty");
`endif

endmodule

/* hw/rtl/gec_back.sv */
// ----------------------------------------------------------------------------
// gec_back
// Builds the partition record: sector count, type code, byte products.
// ----------------------------------------------------------------------------
module gec_back
   import gec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [SS_W-1:0] sector_size,
   input  logic            job_valid,
   input  job_type         job,
   output logic            pop,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [1:0]      rsp_tuser,
   output logic [335:0]    rsp_tdata
);

   typedef struct packed {
      logic              emit;
      logic              stopped;
      logic [IDX_W-1:0]  index;
      logic [63:0]       first;
      logic [63:0]       count;
      logic [CODE_W-1:0] code;
      logic [63:0]       attr;
   } rec_type;

   logic        adv;
   logic        v1_ff, v2_ff, v3_ff;
   rec_type     s1_ff, s1_in, s2_ff;
   logic [SS_W+31:0] f_lo_ff, c_lo_ff;
   logic [31:0]      f_hi_ff, c_hi_ff;
   logic [63:0]      offset, size;
   logic [1:0]       user_ff, user_in;
   logic [335:0]     data_ff, data_in;

   assign adv        = !v3_ff || rsp_tready;
   assign pop        = adv && job_valid;
   assign rsp_tvalid = v3_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tdata  = data_ff;

   always_comb begin
      s1_in.emit    = job.emit;
      s1_in.stopped = job.stopped;
      s1_in.index   = job.index;
      s1_in.first   = job.first;
      s1_in.count   = job.last - job.first + 64'd1;
      s1_in.code    = classify(job.guid_lo, job.guid_hi);
      s1_in.attr    = job.attr;
   end

   always_comb begin
      offset  = 64'(f_lo_ff) + {f_hi_ff, 32'd0};
      size    = 64'(c_lo_ff) + {c_hi_ff, 32'd0};
      user_in = {s2_ff.stopped, s2_ff.emit};
      data_in = '0;
      if (s2_ff.emit) begin
         data_in = {2'b00, s2_ff.attr, s2_ff.code, size, offset, s2_ff.count,
                    s2_ff.first, s2_ff.index};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= s1_in;
         s2_ff   <= s1_ff;
         f_lo_ff <= (SS_W+32)'(s1_ff.first[31:0]) * (SS_W+32)'(sector_size);
         f_hi_ff <= 32'(s1_ff.first[63:32]) * 32'(sector_size);
         c_lo_ff <= (SS_W+32)'(s1_ff.count[31:0]) * (SS_W+32)'(sector_size);
         c_hi_ff <= 32'(s1_ff.count[63:32]) * 32'(sector_size);
         user_ff <= user_in;
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

`ifndef SYNTHESIS
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> !(s2_ff.emit && s2_ff.stopped))
      else $error("record both emitted and stopped");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v2_ff) && $stable(v1_ff))
      else $error("inner stage moved during output stall");
`endif

endmodule

/* hw/rtl/gpt_entry_decoder.sv */
// ----------------------------------------------------------------------------
// gpt_entry_decoder
// Decodes GPT partition entries into partition records, one record per entry.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: new_table; tdata: entry fields
//   rsp      out  rsp_tvalid/rsp_tready  tuser: emitted, stopped; tdata: record
//   csr      in   csr_valid/csr_ready    csr_index, csr_data
//
// One entry per cycle while the queue has room and no settle is running; rsp_tvalid
// for a record rises once its entry has passed the queue write on the accepting
// edge and then three back stages: classify, split products, product sum. The
// position, offset and halt registers of the front close their loop through one
// combinational 64-bit add and compare.
// After reset and after every register write, req_tready stays low while the
// array base product settles; csr writes are always taken.
// A stall on rsp holds the back stages; the four-deep queue keeps the front
// taking entries until it fills.
// ----------------------------------------------------------------------------
module gpt_entry_decoder
   import gec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // new_table
   // type_guid_low, type_guid_high, first_lba, last_lba, attr_bits
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // emitted, stopped
   // part_index, start_lba, sector_total, start_offset, size_in_bytes,
   // type_code, attr_out, 2 pad bits
   output logic [335:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   cfg_type cfg;
   job_type push_job, pop_job;
   logic    push, queue_full, pop, pop_valid;

   gec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .new_table  (req_tuser),
      .guid_lo    (req_tdata[63:0]),
      .guid_hi    (req_tdata[127:64]),
      .first_lba  (req_tdata[191:128]),
      .last_lba   (req_tdata[255:192]),
      .attr_bits  (req_tdata[319:256]),
      .queue_full (queue_full),
      .push       (push),
      .job        (push_job)
   );

   gec_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_job)
   );

   gec_back u_back (
      .clock       (clock),
      .reset       (reset),
      .sector_size (cfg.sector_size),
      .job_valid   (pop_valid),
      .job         (pop_job),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

/* verif/gpt_record_checker.sv */
// ----------------------------------------------------------------------------
// gpt_record_checker
// Watches the entry, record and register channels of the GPT entry decoder.
// Keeps its own copy of the header registers and table counters, predicts
// one record per accepted entry, and compares the records in order, field by
// field. Reports the failure count and the number of records still owed.
// ----------------------------------------------------------------------------
module gpt_record_checker
   import gec_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic         req_tuser,
   input  logic [319:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [1:0]   rsp_tuser,
   input  logic [335:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data,
   output int           fail_count,
   output int           pending,
   output int           entries_seen,
   output int           records_seen,
   output int           stops_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                NUM_KINDS    = 9;
   localparam int                REPORT_LIMIT = 100;
   localparam logic [CODE_W-1:0] KIND_UNKNOWN = 4'd9;

   // type GUIDs as two little-endian disk halves, in type code order
   localparam logic [63:0] KIND_LO [NUM_KINDS] = '{
      64'h11D2F81FC12A7328, 64'h4433B9E5EBD0A0A2, 64'h4DB80B5CE3C9E316,
      64'h4D4006D1DE94BBA4, 64'h477284830FC63DAF, 64'h43C4A4AB0657FD6D,
      64'h44C2F507E6D6D379, 64'h11AA000048465300, 64'h11AA00007C3457EF
   };
   localparam logic [63:0] KIND_HI [NUM_KINDS] = '{
      64'h3BC93EC9A0004BBA, 64'hC79926B7B668C087, 64'hAE1502F02DF97D81,
      64'hACD67901D5BF6AA1, 64'hE47D47D8693D798E, 64'h4F4F4BC83309E584,
      64'h28F93D2A8F233CA2, 64'hACEC4365300011AA, 64'hACEC4365300011AA
   };

   typedef struct packed {
      logic              emitted;
      logic              stopped;
      logic [IDX_W-1:0]  part_index;
      logic [63:0]       start_lba;
      logic [63:0]       sector_total;
      logic [63:0]       start_offset;
      logic [63:0]       size_in_bytes;
      logic [CODE_W-1:0] type_code;
      logic [63:0]       attr_out;
   } part_record_type;

   // header registers
   logic [SS_W-1:0] sector_size;
   logic [63:0]     array_lba;
   logic [31:0]     table_entries;
   logic [31:0]     entry_size;
   logic [63:0]     disk_bytes;

   // table walk
   logic [10:0]     next_entry;
   logic [10:0]     kept_entries;
   logic            table_done;

   part_record_type expected_records[$];
   int              rsp_seen;

   function automatic logic [CODE_W-1:0] type_code_of(input logic [63:0] lo,
                                                      input logic [63:0] hi);
      for (int k = 0; k < NUM_KINDS; k++) begin
         if (KIND_LO[k] == lo && KIND_HI[k] == hi) begin
            return CODE_W'(k);
         end
      end
      return KIND_UNKNOWN;
   endfunction

   function automatic part_record_type decode_entry(input logic fresh,
                                                    input logic [319:0] bits);
      part_record_type rec;
      logic [63:0]     first;
      logic [63:0]     last;
      logic [63:0]     entry_end;
      logic [31:0]     limit;
      rec   = '0;
      first = bits[191:128];
      last  = bits[255:192];
      if (fresh) begin
         next_entry   = '0;
         kept_entries = '0;
         table_done   = 1'b0;
      end
      // disabled header: state untouched
      if (sector_size == '0 || entry_size < MIN_ENTRY_BYTES || table_entries == '0) begin
         return rec;
      end
      if (table_done) begin
         rec.stopped = 1'b1;
         return rec;
      end
      limit = (table_entries > 32'(MAX_ENTRIES)) ? 32'(MAX_ENTRIES) : table_entries;
      entry_end = array_lba * 64'(sector_size) + 64'(next_entry) * 64'(entry_size)
                + 64'(entry_size);
      // count reached, or entry would reach past the end of storage
      if (32'(next_entry) >= limit || entry_end > disk_bytes) begin
         table_done  = 1'b1;
         rec.stopped = 1'b1;
         return rec;
      end
      next_entry++;
      if (bits[127:0] == '0 || first > last) begin
         return rec;
      end
      rec.emitted       = 1'b1;
      rec.part_index    = kept_entries[IDX_W-1:0];
      rec.start_lba     = first;
      rec.sector_total  = last - first + 64'd1;
      rec.start_offset  = first * 64'(sector_size);
      rec.size_in_bytes = rec.sector_total * 64'(sector_size);
      rec.type_code     = type_code_of(bits[63:0], bits[127:64]);
      rec.attr_out      = bits[319:256];
      kept_entries++;
      return rec;
   endfunction

   function automatic void write_register(input logic [2:0] index, input logic [63:0] data);
      case (index)
         REG_SECTOR_SIZE:     sector_size   = data[SS_W-1:0];
         REG_ARRAY_START_LBA: array_lba     = data;
         REG_ENTRY_COUNT:     table_entries = data[31:0];
         REG_ENTRY_BYTES:     entry_size    = data[31:0];
         REG_STORAGE_BYTES:   disk_bytes    = data;
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         if (fail_count < REPORT_LIMIT) begin
            $display("%0t: record %0d %s: expected %0h, got %0h",
                     $time, rsp_seen, name, want, got);
         end
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : track
      part_record_type want;
      part_record_type got;
      if (reset) begin
         sector_size   = 17'd512;
         array_lba     = 64'd2;
         table_entries = 32'd128;
         entry_size    = 32'd128;
         disk_bytes    = '0;
         next_entry    = '0;
         kept_entries  = '0;
         table_done    = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            write_register(csr_index, csr_data);
         end
         // records leave after their entry, so match before queueing new ones
         if (rsp_tvalid && rsp_tready) begin
            got.emitted       = rsp_tuser[0];
            got.stopped       = rsp_tuser[1];
            got.part_index    = rsp_tdata[9:0];
            got.start_lba     = rsp_tdata[73:10];
            got.sector_total  = rsp_tdata[137:74];
            got.start_offset  = rsp_tdata[201:138];
            got.size_in_bytes = rsp_tdata[265:202];
            got.type_code     = rsp_tdata[269:266];
            got.attr_out      = rsp_tdata[333:270];
            if (got.emitted === 1'b1) begin
               records_seen++;
            end
            if (got.stopped === 1'b1) begin
               stops_seen++;
            end
            if (expected_records.size() == 0) begin
               if (fail_count < REPORT_LIMIT) begin
                  $display("%0t: record %0d with no entry waiting: expected none, got %0h",
                           $time, rsp_seen, {rsp_tuser, rsp_tdata});
               end
               fail_count++;
            end else begin
               want = expected_records.pop_front();
               compare_field("emitted", 64'(want.emitted), 64'(got.emitted));
               compare_field("stopped", 64'(want.stopped), 64'(got.stopped));
               compare_field("part_index", 64'(want.part_index), 64'(got.part_index));
               compare_field("start_lba", want.start_lba, got.start_lba);
               compare_field("sector_total", want.sector_total, got.sector_total);
               compare_field("start_offset", want.start_offset, got.start_offset);
               compare_field("size_in_bytes", want.size_in_bytes, got.size_in_bytes);
               compare_field("type_code", 64'(want.type_code), 64'(got.type_code));
               compare_field("attr_out", want.attr_out, got.attr_out);
            end
            rsp_seen++;
         end
         if (req_tvalid && req_tready) begin
            expected_records.insert(expected_records.size(),
                                    decode_entry(req_tuser, req_tdata));
            entries_seen++;
         end
      end
      pending <= expected_records.size();
   end

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the GPT entry decoder: a short directed table covering every
// type GUID, skipped entries, wrap-around, count limit, truncation and the
// disabled headers, then random header settings each followed by a few
// tables of random entries. Both stream sides idle at random; the record
// checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import gec_pkg::*;

   typedef struct packed {
      logic [2:0]  index;
      logic [63:0] value;
   } reg_write_type;

   logic         clock;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic         req_tuser  = 1'b0;   // new_table
   // type_guid_low, type_guid_high, first_lba, last_lba, attr_bits
   logic [319:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [1:0]   rsp_tuser;           // emitted, stopped
   // part_index, start_lba, sector_total, start_offset, size_in_bytes,
   // type_code, attr_out, 2 pad bits
   logic [335:0] rsp_tdata;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = '0;
   logic [63:0]  csr_data   = '0;

   int           fail_count;
   int           pending;
   int           entries_seen;
   int           records_seen;
   int           stops_seen;

   reg_write_type staged_writes[$];
   int           tx_run, rx_run;
   bit           tx_steady, rx_steady;
   int           live_items;
   int           settings_count;

   gpt_entry_decoder dut (.*);

   gpt_record_checker record_check (.*);

   initial begin : clock_gen
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [319:0] pack_entry(input logic [63:0] lo, input logic [63:0] hi,
                                               input logic [63:0] first,
                                               input logic [63:0] last,
                                               input logic [63:0] attr);
      return {attr, last, first, hi, lo};
   endfunction

   // idle cycles before the next item; each run either idles at random or has none
   function automatic int draw_gap(inout int run_left, inout bit steady);
      if (run_left == 0) begin
         run_left = $urandom_range(10, 60);
         steady   = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      return steady ? 0 : $urandom_range(0, 6);
   endfunction

   function automatic logic [319:0] random_entry();
      logic [63:0] lo, hi, first, last, a, b;
      int          k;
      int          flip;
      k    = $urandom_range(0, KNOWN_TYPES - 1);
      lo   = TYPE_LO[k];
      hi   = TYPE_HI[k];
      flip = $urandom_range(0, 127);
      a    = rand64();
      b    = rand64();
      case ($urandom_range(0, 19))
         0, 1: begin
            lo = '0;
            hi = '0;
         end
         2: lo = '0;
         3: hi = '0;
         4: begin
            // near miss on one bit of a known GUID
            if (flip < 64) begin
               lo[flip] = ~lo[flip];
            end else begin
               hi[flip - 64] = ~hi[flip - 64];
            end
         end
         5: hi = rand64();
         6, 7: begin
            lo = rand64();
            hi = rand64();
         end
         default: ;
      endcase
      case ($urandom_range(0, 19))
         0: begin
            first = a | 64'h8000_0000_0000_0000;
            last  = b & 64'h7FFF_FFFF_FFFF_FFFF;
         end
         1: begin
            first = '0;
            last  = '1;
         end
         2: begin
            first = '1;
            last  = '1;
         end
         3: begin
            first = a;
            last  = a;
         end
         4, 5: begin
            first = a;
            last  = a + 64'(b[19:0]);
         end
         default: begin
            first = 64'(a[20:0]);
            last  = first + 64'(b[21:0]);
         end
      endcase
      return pack_entry(lo, hi, first, last, rand64());
   endfunction

   task automatic send_entry(input logic fresh, input logic [319:0] bits);
      int gap;
      gap = draw_gap(tx_run, tx_steady);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fresh;
      req_tdata  <= bits;
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every record has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   function automatic void stage_write(input logic [2:0] index, input logic [63:0] value);
      reg_write_type w;
      w.index = index;
      w.value = value;
      staged_writes.insert(staged_writes.size(), w);
   endfunction

   task automatic apply_writes();
      foreach (staged_writes[i]) begin
         csr_valid <= 1'b1;
         csr_index <= staged_writes[i].index;
         csr_data  <= staged_writes[i].value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      staged_writes.delete();
      settings_count++;
   endtask

   task automatic random_phase();
      logic [SS_W-1:0] ss;
      logic [63:0]     lba, disk, junk;
      logic [31:0]     cnt, eb, slack;
      int              limit, len, cut;
      bit              live, fresh;
      case ($urandom_range(0, 19))
         0:       ss = '0;
         1:       ss = 17'd65536;
         2:       ss = 17'd1;
         3, 4, 5, 6, 7, 8:      ss = 17'd512;
         9, 10, 11, 12, 13:     ss = 17'd4096;
         default: ss = SS_W'($urandom_range(1, 65536));
      endcase
      case ($urandom_range(0, 19))
         0:       eb = $urandom_range(0, 127);
         1:       eb = 32'hFFFF_FFFF;
         2:       eb = $urandom;
         3, 4, 5, 6, 7, 8, 9, 10:   eb = 32'd128;
         11, 12, 13, 14, 15:        eb = 32'd256;
         default: eb = $urandom_range(128, 4096);
      endcase
      case ($urandom_range(0, 19))
         0:       cnt = '0;
         1:       cnt = 32'hFFFF_FFFF;
         2:       cnt = $urandom_range(MAX_ENTRIES, 5000);
         3:       cnt = 32'd1;
         default: cnt = $urandom_range(2, 24);
      endcase
      case ($urandom_range(0, 9))
         0:       lba = rand64();
         1:       lba = '1;
         default: lba = 64'($urandom_range(1, 64));
      endcase
      live  = ss != '0 && eb >= MIN_ENTRY_BYTES && cnt != '0;
      limit = (cnt > 32'(MAX_ENTRIES)) ? MAX_ENTRIES : int'(cnt);
      len   = (limit > 20) ? $urandom_range(4, 20) : limit;
      len  += $urandom_range(0, 3);
      // storage sized so that truncation falls somewhere along the table
      cut   = $urandom_range(0, len + 1);
      slack = $urandom_range(0, (eb == '0) ? 0 : eb - 1);
      case ($urandom_range(0, 9))
         0:       disk = '1;
         1:       disk = '0;
         2:       disk = rand64();
         default: disk = lba * 64'(ss) + 64'(cut) * 64'(eb) + 64'(slack);
      endcase
      junk = ($urandom_range(0, 3) == 0) ? rand64() : '0;
      drain();
      stage_write(REG_SECTOR_SIZE, {junk[63:SS_W], ss});
      stage_write(REG_ARRAY_START_LBA, lba);
      stage_write(REG_ENTRY_COUNT, {junk[63:32], cnt});
      stage_write(REG_ENTRY_BYTES, {junk[31:0], eb});
      stage_write(REG_STORAGE_BYTES, disk);
      if ($urandom_range(0, 7) == 0) begin
         stage_write(REG_STORAGE_BYTES + 3'($urandom_range(1, 3)), rand64());
      end
      apply_writes();
      if (!live) begin
         repeat ($urandom_range(1, 3)) send_entry(1'($urandom_range(0, 1)), random_entry());
         return;
      end
      repeat ($urandom_range(1, 3)) begin
         for (int i = 0; i < len; i++) begin
            fresh = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 24) == 0);
            send_entry(fresh, random_entry());
            live_items++;
         end
      end
   endtask

   initial begin : rsp_sink
      int stall;
      forever begin
         stall = draw_gap(rx_run, rx_steady);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : stimulus
      logic [63:0] first;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // power-on header has zero storage: the first entry truncates, then halted
      send_entry(1'b1, pack_entry(TYPE_LO[0], TYPE_HI[0], 64'd34, 64'd1057, rand64()));
      send_entry(1'b0, pack_entry(TYPE_LO[1], TYPE_HI[1], 64'd2048, 64'd4095, rand64()));

      drain();
      stage_write(REG_SECTOR_SIZE, 64'd512);
      stage_write(REG_ARRAY_START_LBA, 64'd2);
      stage_write(REG_ENTRY_COUNT, 64'd16);
      stage_write(REG_ENTRY_BYTES, 64'd128);
      stage_write(REG_STORAGE_BYTES, '1);
      for (int k = 1; k <= 3; k++) begin
         stage_write(REG_STORAGE_BYTES + 3'(k), rand64());
      end
      apply_writes();
      for (int k = 0; k < KNOWN_TYPES; k++) begin
         first = 64'(k) * 64'd4096 + 64'd34;
         send_entry(k == 0, pack_entry(TYPE_LO[k], TYPE_HI[k], first, first + 64'd4095,
                                       rand64()));
      end
      send_entry(1'b0, pack_entry(rand64(), rand64(), 64'd100000, 64'd100000, rand64()));
      send_entry(1'b0, pack_entry('0, '0, 64'd34, 64'd99, rand64()));
      send_entry(1'b0, pack_entry(TYPE_LO[1], TYPE_HI[1], 64'd100, 64'd99, rand64()));
      // sector total wraps to zero
      send_entry(1'b0, pack_entry(TYPE_LO[4], TYPE_HI[4], '0, '1, '0));
      send_entry(1'b0, pack_entry('1, '1, '1, '1, '1));
      // two more entries fill the count, then count reached and halted
      repeat (4) send_entry(1'b0, random_entry());

      drain();
      stage_write(REG_SECTOR_SIZE, '0);
      apply_writes();
      send_entry(1'b1, random_entry());
      drain();
      stage_write(REG_SECTOR_SIZE, 64'd65536);
      stage_write(REG_ENTRY_BYTES, 64'd127);
      apply_writes();
      send_entry(1'b1, random_entry());
      drain();
      stage_write(REG_ENTRY_BYTES, 64'hFFFF_FFFF);
      stage_write(REG_ENTRY_COUNT, '0);
      apply_writes();
      send_entry(1'b0, random_entry());

      while (live_items < 750) begin
         random_phase();
      end

      drain();
      repeat (8) @(posedge clock);
      $display("summary: %0d entries under %0d header settings", entries_seen, settings_count);
      $display("summary: %0d partition records and %0d stop responses compared",
               records_seen, stops_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("timeout: decoder stopped making progress");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/gec_pkg.sv
hw/rtl/gec_csr.sv
hw/rtl/gec_front.sv
hw/rtl/gec_fifo.sv
hw/rtl/gec_back.sv
hw/rtl/gpt_entry_decoder.sv
verif/gpt_record_checker.sv
verif/tb_top.sv
